[hdl/mtk_pkg.sv]
package mtk_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BUTTON_CHANNEL = 3'd0,
    CFG_NAV_CHANNEL    = 3'd1,
    CFG_JOG_HIGH_CC    = 3'd2,
    CFG_JOG_LOW_CC     = 3'd3,
    CFG_RELEASE_MS     = 3'd4,
    CFG_REVERSE_COUNT  = 3'd5,
    CFG_MIN_STEP       = 3'd6
  } cfg_addr_t;

  typedef struct packed {
    logic [3:0]  button_channel;
    logic [3:0]  nav_channel;
    logic [6:0]  jog_high_cc;
    logic [6:0]  jog_low_cc;
    logic [15:0] release_ms;
    logic [1:0]  reverse_count;
    logic [5:0]  min_step;
  } cfg_t;

  // input operations
  localparam logic OP_MIDI_BYTE = 1'b0;
  localparam logic OP_POLL      = 1'b1;

  // midi status codes
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
  localparam logic [3:0] KIND_CTRL      = 4'hB;
  localparam logic [3:0] KIND_PROGRAM   = 4'hC;
  localparam logic [3:0] KIND_PRESSURE  = 4'hD;

  // key codes
  localparam logic [3:0] KEY_ATTACK = 4'd0;
  localparam logic [3:0] KEY_USE    = 4'd1;
  localparam logic [3:0] KEY_RUN    = 4'd2;
  localparam logic [3:0] KEY_DIGIT1 = 4'd3;
  localparam logic [3:0] KEY_DIGIT2 = 4'd4;
  localparam logic [3:0] KEY_DIGIT3 = 4'd5;
  localparam logic [3:0] KEY_DIGIT4 = 4'd6;
  localparam logic [3:0] KEY_UP     = 4'd7;
  localparam logic [3:0] KEY_DOWN   = 4'd8;
  localparam logic [3:0] KEY_BACK   = 4'd9;
  localparam logic [3:0] KEY_SELECT = 4'd10;
  localparam logic [3:0] KEY_LEFT   = 4'd11;
  localparam logic [3:0] KEY_RIGHT  = 4'd12;

  typedef enum logic [1:0] {
    DIR_IDLE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MSG_NOTE_OFF = 2'd0,
    MSG_NOTE_ON  = 2'd1,
    MSG_CTRL     = 2'd2,
    MSG_POLL     = 2'd3
  } msg_kind_t;

  // classified message from the parser to the event unit
  typedef struct packed {
    msg_kind_t   kind;
    logic [3:0]  channel;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [31:0] time_ms;
  } msg_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic       pressed;
    logic [3:0] key_code;
    logic       last;
  } out_item_t;

endpackage

[hdl/mtk_fifo.sv]
module mtk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hdl/mtk_front.sv]
module mtk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  mtk_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              msg_full,
  output logic              msg_push,
  output mtk_pkg::msg_t     msg
);

  import mtk_pkg::*;

  logic [7:0] running_status_r, running_status_nxt;
  logic       in_sysex_r, in_sysex_nxt;
  logic [1:0] data_count_r, data_count_nxt;
  logic [6:0] first_data_r, first_data_nxt;
  logic       accept;
  logic [7:0] b;
  logic [3:0] kind;
  logic       need_one;

  assign in_full = msg_full;
  assign accept  = in_push & ~msg_full;
  assign b       = in_item.data_byte;
  assign kind    = running_status_r[7:4];
  assign need_one = (kind == KIND_PROGRAM) || (kind == KIND_PRESSURE);

  // byte parser: running status, sysex skip, data byte count
  always_comb begin
    running_status_nxt = running_status_r;
    in_sysex_nxt       = in_sysex_r;
    data_count_nxt     = data_count_r;
    first_data_nxt     = first_data_r;
    msg_push           = 1'b0;
    msg.kind           = MSG_POLL;
    msg.channel        = running_status_r[3:0];
    msg.data1          = first_data_r;
    msg.data2          = b[6:0];
    msg.time_ms        = in_item.time_ms;
    if (accept) begin
      if (in_item.operation == OP_POLL) begin
        msg_push = 1'b1;
      end else if (b[7]) begin
        if (b < ST_SYSEX_START) begin
          running_status_nxt = b;
          data_count_nxt     = 2'd0;
        end else if (b == ST_SYSEX_START) begin
          in_sysex_nxt = 1'b1;
        end else if (b == ST_SYSEX_END) begin
          in_sysex_nxt = 1'b0;
        end
      end else if (!in_sysex_r) begin
        if (!need_one && data_count_r == 2'd0) begin
          first_data_nxt = b[6:0];
          data_count_nxt = 2'd1;
        end else begin
          if (need_one) begin
            first_data_nxt = b[6:0];
          end
          data_count_nxt = 2'd0;
          // only notes and controllers lead anywhere
          if (kind == KIND_NOTE_OFF || (kind == KIND_NOTE_ON && b == 8'd0)) begin
            msg_push = 1'b1;
            msg.kind = MSG_NOTE_OFF;
          end else if (kind == KIND_NOTE_ON) begin
            msg_push = 1'b1;
            msg.kind = MSG_NOTE_ON;
          end else if (kind == KIND_CTRL) begin
            msg_push = 1'b1;
            msg.kind = MSG_CTRL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_status_r <= '0;
      in_sysex_r       <= 1'b0;
      data_count_r     <= '0;
      first_data_r     <= '0;
    end else begin
      running_status_r <= running_status_nxt;
      in_sysex_r       <= in_sysex_nxt;
      data_count_r     <= data_count_nxt;
      first_data_r     <= first_data_nxt;
    end
  end

endmodule

[hdl/mtk_back.sv]
module mtk_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mtk_pkg::cfg_t      cfg,
  input  logic               msg_empty,
  input  mtk_pkg::msg_t      msg,
  output logic               msg_pop,
  input  logic               res_full,
  output logic               res_push,
  output mtk_pkg::out_item_t res
);

  import mtk_pkg::*;

  // note number to key code, msb is the hit flag
  function automatic logic [4:0] note_key(input logic [3:0] ch, input logic [6:0] note,
                                          input cfg_t c);
    logic [4:0] k;
    k = 5'd0;
    if (ch == c.button_channel) begin
      case (note)
        7'd10:   k = {1'b1, KEY_ATTACK};
        7'd9:    k = {1'b1, KEY_USE};
        7'd8:    k = {1'b1, KEY_RUN};
        7'd15:   k = {1'b1, KEY_DIGIT1};
        7'd16:   k = {1'b1, KEY_DIGIT2};
        7'd17:   k = {1'b1, KEY_DIGIT3};
        7'd18:   k = {1'b1, KEY_DIGIT4};
        default: k = k;
      endcase
    end
    if (ch == c.nav_channel) begin
      case (note)
        7'd4:    k = {1'b1, KEY_UP};
        7'd3:    k = {1'b1, KEY_DOWN};
        7'd7:    k = {1'b1, KEY_BACK};
        7'd6:    k = {1'b1, KEY_SELECT};
        default: k = k;
      endcase
    end
    return k;
  endfunction

  // jog state
  logic [6:0]  pend_high_r, pend_high_nxt;
  logic        pend_high_ok_r, pend_high_ok_nxt;
  logic [6:0]  pend_low_r, pend_low_nxt;
  logic        pend_low_ok_r, pend_low_ok_nxt;
  logic [6:0]  last_high_r, last_high_nxt;
  logic        last_high_ok_r, last_high_ok_nxt;
  logic [13:0] prev_pos_r, prev_pos_nxt;
  logic        prev_ok_r, prev_ok_nxt;
  logic [31:0] last_move_r, last_move_nxt;
  dir_t        dir_r, dir_nxt;
  logic [2:0]  streak_r, streak_nxt;
  logic        step_r;

  logic [1:0]         ev_n;
  logic [4:0]         ev0, ev1;
  logic [4:0]         nk;
  logic               is_hi, is_lo;
  logic [6:0]         hi;
  logic [13:0]        cur;
  logic signed [15:0] raw, adj, neg_min;
  logic [2:0]         streak_inc;
  logic               reverse;
  logic [31:0]        elapsed;
  logic               commit;

  assign streak_inc = streak_r + 3'd1;
  assign reverse    = (streak_inc >= {1'b0, cfg.reverse_count});
  assign elapsed    = msg.time_ms - last_move_r;
  assign neg_min    = -$signed({10'b0, cfg.min_step});

  // events and next jog state for the message at the head of the queue
  always_comb begin
    ev_n             = 2'd0;
    ev0              = '0;
    ev1              = '0;
    nk               = note_key(msg.channel, msg.data1, cfg);
    is_hi            = (msg.channel == cfg.button_channel) && (msg.data1 == cfg.jog_high_cc);
    is_lo            = (msg.channel == cfg.button_channel) && !is_hi &&
                       (msg.data1 == cfg.jog_low_cc);
    pend_high_nxt    = pend_high_r;
    pend_high_ok_nxt = pend_high_ok_r;
    pend_low_nxt     = pend_low_r;
    pend_low_ok_nxt  = pend_low_ok_r;
    last_high_nxt    = last_high_r;
    last_high_ok_nxt = last_high_ok_r;
    prev_pos_nxt     = prev_pos_r;
    prev_ok_nxt      = prev_ok_r;
    last_move_nxt    = last_move_r;
    dir_nxt          = dir_r;
    streak_nxt       = streak_r;
    hi               = '0;
    cur              = '0;
    raw              = '0;
    adj              = '0;
    case (msg.kind)
      MSG_NOTE_OFF: begin
        if (nk[4]) begin
          ev_n = 2'd1;
          ev0  = {1'b0, nk[3:0]};
        end
      end
      MSG_NOTE_ON: begin
        if (nk[4]) begin
          ev_n = 2'd1;
          ev0  = {1'b1, nk[3:0]};
        end
      end
      MSG_CTRL: begin
        if (is_hi) begin
          pend_high_nxt    = msg.data2;
          pend_high_ok_nxt = 1'b1;
          last_high_nxt    = msg.data2;
          last_high_ok_nxt = 1'b1;
        end else if (is_lo) begin
          pend_low_nxt    = msg.data2;
          pend_low_ok_nxt = 1'b1;
        end
        hi = pend_high_ok_nxt ? pend_high_nxt : last_high_nxt;
        if ((is_hi || is_lo) && (pend_high_ok_nxt || last_high_ok_nxt) && pend_low_ok_nxt) begin
          cur = {hi, pend_low_nxt};
          raw = $signed({2'b0, cur}) - $signed({2'b0, prev_pos_r});
          if (raw > 16'sd8192) begin
            adj = raw - 16'sd16384;
          end else if (raw < -16'sd8192) begin
            adj = raw + 16'sd16384;
          end else begin
            adj = raw;
          end
          if (prev_ok_r && cur != prev_pos_r) begin
            if (adj[15]) begin
              if (dir_r == DIR_RIGHT) begin
                streak_nxt = streak_inc;
                if (reverse) begin
                  ev_n       = 2'd2;
                  ev0        = {1'b0, KEY_RIGHT};
                  ev1        = {1'b1, KEY_LEFT};
                  dir_nxt    = DIR_LEFT;
                  streak_nxt = '0;
                end
              end else if (dir_r == DIR_IDLE && adj <= neg_min) begin
                ev_n       = 2'd1;
                ev0        = {1'b1, KEY_LEFT};
                dir_nxt    = DIR_LEFT;
                streak_nxt = '0;
              end
            end else begin
              if (dir_r == DIR_LEFT) begin
                streak_nxt = streak_inc;
                if (reverse) begin
                  ev_n       = 2'd2;
                  ev0        = {1'b0, KEY_LEFT};
                  ev1        = {1'b1, KEY_RIGHT};
                  dir_nxt    = DIR_RIGHT;
                  streak_nxt = '0;
                end
              end else if (dir_r == DIR_IDLE && adj >= -neg_min) begin
                ev_n       = 2'd1;
                ev0        = {1'b1, KEY_RIGHT};
                dir_nxt    = DIR_RIGHT;
                streak_nxt = '0;
              end
            end
            last_move_nxt = msg.time_ms;
          end
          prev_pos_nxt     = cur;
          prev_ok_nxt      = 1'b1;
          pend_high_ok_nxt = 1'b0;
          pend_low_ok_nxt  = 1'b0;
        end
      end
      MSG_POLL: begin
        if (dir_r != DIR_IDLE && elapsed > {16'b0, cfg.release_ms}) begin
          ev_n    = 2'd1;
          ev0     = {1'b0, (dir_r == DIR_RIGHT) ? KEY_RIGHT : KEY_LEFT};
          dir_nxt = DIR_IDLE;
        end
      end
      default: ev_n = 2'd0;
    endcase
  end

  // one event a cycle unless res_full; pop with final event or if none
  always_comb begin
    res_push = 1'b0;
    msg_pop  = 1'b0;
    res      = {(step_r ? ev1 : ev0), (step_r || ev_n == 2'd1)};
    if (!msg_empty) begin
      if (ev_n == 2'd0) begin
        msg_pop = 1'b1;
      end else if (!res_full) begin
        res_push = 1'b1;
        msg_pop  = step_r || (ev_n == 2'd1);
      end
    end
  end

  assign commit = msg_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= 1'b0;
      pend_high_ok_r <= 1'b0;
      pend_low_ok_r  <= 1'b0;
      last_high_ok_r <= 1'b0;
      prev_ok_r      <= 1'b0;
      last_move_r    <= '0;
      dir_r          <= DIR_IDLE;
      streak_r       <= '0;
    end else begin
      if (commit) begin
        step_r         <= 1'b0;
        pend_high_ok_r <= pend_high_ok_nxt;
        pend_low_ok_r  <= pend_low_ok_nxt;
        last_high_ok_r <= last_high_ok_nxt;
        prev_ok_r      <= prev_ok_nxt;
        last_move_r    <= last_move_nxt;
        dir_r          <= dir_nxt;
        streak_r       <= streak_nxt;
      end else if (res_push) begin
        step_r <= 1'b1;
      end
    end
  end

  // jog payload, qualified by the valid flags
  always_ff @(posedge clk) begin
    if (commit) begin
      pend_high_r <= pend_high_nxt;
      pend_low_r  <= pend_low_nxt;
      last_high_r <= last_high_nxt;
      prev_pos_r  <= prev_pos_nxt;
    end
  end

endmodule

[hdl/midi_to_key_event_decoder.sv]
// MIDI to key event decoder. Items are MIDI bytes or poll ticks, each with a
// millisecond timestamp; results are key press and release items, at most
// two per input item, the final one of each input marked by last. A byte
// parser takes one item per clock while the message queue is not full and
// places notes, controller messages and polls into a small message queue;
// an event unit drains it, writing one result per clock into the result
// queue while that queue is not full. A jog reversal (release plus press)
// writes its two results in turn through the result queue's single write
// port. After reset the block accepts items at once; configuration writes
// take effect on the next clock.
module midi_to_key_event_decoder #(
  parameter int MSG_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  mtk_pkg::in_item_t                   in_item,
  output logic                                in_full,
  output logic                                out_empty,
  input  logic                                out_pop,
  output mtk_pkg::out_item_t                  out_item,
  input  logic                                cfg_wr_en,
  input  logic [mtk_pkg::CFG_ADDR_W-1:0]      cfg_index,
  input  logic [mtk_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import mtk_pkg::*;

  localparam int MSG_W = $bits(msg_t);
  localparam int RES_W = $bits(out_item_t);

  cfg_t      cfg_r;
  msg_t      msg_in, msg_head;
  logic      msg_push, msg_full, msg_pop, msg_empty;
  out_item_t res;
  logic      res_push, res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_channel <= 4'd2;
      cfg_r.nav_channel    <= 4'd15;
      cfg_r.jog_high_cc    <= 7'd55;
      cfg_r.jog_low_cc     <= 7'd77;
      cfg_r.release_ms     <= 16'd80;
      cfg_r.reverse_count  <= 2'd3;
      cfg_r.min_step       <= 6'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BUTTON_CHANNEL: cfg_r.button_channel <= cfg_data[3:0];
        CFG_NAV_CHANNEL:    cfg_r.nav_channel    <= cfg_data[3:0];
        CFG_JOG_HIGH_CC:    cfg_r.jog_high_cc    <= cfg_data[6:0];
        CFG_JOG_LOW_CC:     cfg_r.jog_low_cc     <= cfg_data[6:0];
        CFG_RELEASE_MS:     cfg_r.release_ms     <= cfg_data[15:0];
        CFG_REVERSE_COUNT:  cfg_r.reverse_count  <= cfg_data[1:0];
        CFG_MIN_STEP:       cfg_r.min_step       <= cfg_data[5:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // byte parser
  mtk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .msg_full (msg_full),
    .msg_push (msg_push),
    .msg      (msg_in)
  );

  // message queue between parser and event unit
  mtk_fifo #(
    .WIDTH (MSG_W),
    .DEPTH (MSG_DEPTH)
  ) u_msg_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (msg_push),
    .wdata (msg_in),
    .full  (msg_full),
    .pop   (msg_pop),
    .rdata (msg_head),
    .empty (msg_empty)
  );

  // event unit
  mtk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .msg_empty (msg_empty),
    .msg       (msg_head),
    .msg_pop   (msg_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  mtk_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

[hdl/mtk_checker.sv]
module mtk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input mtk_pkg::out_item_t out_item
);

  import mtk_pkg::*;

  // reset leaves both queues empty
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not cleared by reset");

  // a waiting item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting item changed before pop");

  // key codes stay in the defined range
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.key_code <= KEY_RIGHT)
    else $error("key code out of range");

  // only a jog reversal gives a non-final item, and it is a jog release
  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_item.last |->
      !out_item.pressed && (out_item.key_code == KEY_LEFT || out_item.key_code == KEY_RIGHT))
    else $error("non-final item is not a jog release");

endmodule

bind midi_to_key_event_decoder mtk_checker u_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mtk_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTS = 40;
  // channel message kinds that map to nothing
  localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] KIND_PITCH_BEND = 4'hE;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  midi_to_key_event_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // decoder state as the block should hold it
  cfg_t dec_cfg;
  logic [7:0] run_status;
  logic sysex_on;
  int byte_count;
  logic [7:0] first_byte;
  logic [6:0] hi_pending, lo_pending, hi_last;
  logic hi_pending_ok, lo_pending_ok, hi_last_ok;
  logic [13:0] jog_pos;
  logic jog_pos_ok;
  logic [31:0] move_stamp;
  dir_t jog_dir;
  int streak;

  out_item_t step_events[$];
  out_item_t key_event_q[$];

  int mismatches = 0;
  int items_sent = 0;
  logic send_gaps = 1'b1;
  logic pop_gaps = 1'b1;
  logic [31:0] now_ms = '0;
  logic [13:0] jog_target = '0;
  int jog_trend = 1;

  function automatic void reset_decoder();
    dec_cfg.button_channel = 4'd2;
    dec_cfg.nav_channel = 4'd15;
    dec_cfg.jog_high_cc = 7'd55;
    dec_cfg.jog_low_cc = 7'd77;
    dec_cfg.release_ms = 16'd80;
    dec_cfg.reverse_count = 2'd3;
    dec_cfg.min_step = 6'd2;
    run_status = '0;
    sysex_on = 1'b0;
    byte_count = 0;
    first_byte = '0;
    hi_pending = '0;
    lo_pending = '0;
    hi_last = '0;
    hi_pending_ok = 1'b0;
    lo_pending_ok = 1'b0;
    hi_last_ok = 1'b0;
    jog_pos = '0;
    jog_pos_ok = 1'b0;
    move_stamp = '0;
    jog_dir = DIR_IDLE;
    streak = 0;
  endfunction

  function automatic void add_event(logic pressed, logic [3:0] key);
    out_item_t ev;
    ev.pressed = pressed;
    ev.key_code = key;
    ev.last = 1'b0;
    if (step_events.size() < 2) step_events.push_back(ev);
  endfunction

  // note number to key code, -1 when unmapped
  function automatic int note_to_key(logic [3:0] ch, logic [7:0] note);
    int k;
    k = -1;
    if (ch == dec_cfg.button_channel) begin
      case (note)
        8'd10: k = KEY_ATTACK;
        8'd9: k = KEY_USE;
        8'd8: k = KEY_RUN;
        8'd15: k = KEY_DIGIT1;
        8'd16: k = KEY_DIGIT2;
        8'd17: k = KEY_DIGIT3;
        8'd18: k = KEY_DIGIT4;
        default: ;
      endcase
    end
    if (ch == dec_cfg.nav_channel) begin
      case (note)
        8'd4: k = KEY_UP;
        8'd3: k = KEY_DOWN;
        8'd7: k = KEY_BACK;
        8'd6: k = KEY_SELECT;
        default: ;
      endcase
    end
    return k;
  endfunction

  // jog controller: assemble position, track direction
  function automatic void take_jog_control(logic [3:0] ch, logic [7:0] ctl, logic [7:0] val,
                                           logic [31:0] stamp);
    logic [6:0] hi;
    int cur;
    int diff;
    if (ch != dec_cfg.button_channel) return;
    if (ctl[6:0] == dec_cfg.jog_high_cc) begin
      hi_pending = val[6:0];
      hi_pending_ok = 1'b1;
      hi_last = val[6:0];
      hi_last_ok = 1'b1;
    end else if (ctl[6:0] == dec_cfg.jog_low_cc) begin
      lo_pending = val[6:0];
      lo_pending_ok = 1'b1;
    end else begin
      return;
    end
    if (hi_pending_ok) hi = hi_pending;
    else if (hi_last_ok) hi = hi_last;
    else return;
    if (!lo_pending_ok) return;

    cur = int'({hi, lo_pending});
    if (jog_pos_ok && cur != int'(jog_pos)) begin
      diff = cur - int'(jog_pos);
      if (diff > 8192) diff -= 16384;
      else if (diff < -8192) diff += 16384;
      if (diff < 0) begin
        if (jog_dir == DIR_RIGHT) begin
          streak++;
          if (streak >= int'(dec_cfg.reverse_count)) begin
            add_event(1'b0, KEY_RIGHT);
            add_event(1'b1, KEY_LEFT);
            jog_dir = DIR_LEFT;
            streak = 0;
          end
        end else if (jog_dir == DIR_IDLE && diff <= -int'(dec_cfg.min_step)) begin
          add_event(1'b1, KEY_LEFT);
          jog_dir = DIR_LEFT;
          streak = 0;
        end
      end else begin
        if (jog_dir == DIR_LEFT) begin
          streak++;
          if (streak >= int'(dec_cfg.reverse_count)) begin
            add_event(1'b0, KEY_LEFT);
            add_event(1'b1, KEY_RIGHT);
            jog_dir = DIR_RIGHT;
            streak = 0;
          end
        end else if (jog_dir == DIR_IDLE && diff >= int'(dec_cfg.min_step)) begin
          add_event(1'b1, KEY_RIGHT);
          jog_dir = DIR_RIGHT;
          streak = 0;
        end
      end
      move_stamp = stamp;
    end
    jog_pos = cur[13:0];
    jog_pos_ok = 1'b1;
    hi_pending_ok = 1'b0;
    hi_pending = '0;
    lo_pending_ok = 1'b0;
    lo_pending = '0;
  endfunction

  // byte parser: running status, sysex skip, message length
  function automatic void take_midi_byte(logic [7:0] b, logic [31:0] stamp);
    logic [3:0] kind;
    logic [3:0] ch;
    int need;
    int k;
    if (b[7]) begin
      if (b < ST_SYSEX_START) begin
        run_status = b;
        byte_count = 0;
      end else if (b == ST_SYSEX_START) begin
        sysex_on = 1'b1;
      end else if (b == ST_SYSEX_END) begin
        sysex_on = 1'b0;
      end
      return;
    end
    if (sysex_on) return;
    kind = run_status[7:4];
    ch = run_status[3:0];
    need = (kind == KIND_PROGRAM || kind == KIND_PRESSURE) ? 1 : 2;
    if (byte_count + 1 < need) begin
      first_byte = b;
      byte_count = 1;
      return;
    end
    if (need == 1) first_byte = b;
    byte_count = 0;
    if (kind == KIND_NOTE_OFF || (kind == KIND_NOTE_ON && b == 8'd0)) begin
      k = note_to_key(ch, first_byte);
      if (k >= 0) add_event(1'b0, k[3:0]);
    end else if (kind == KIND_NOTE_ON) begin
      k = note_to_key(ch, first_byte);
      if (k >= 0) add_event(1'b1, k[3:0]);
    end else if (kind == KIND_CTRL) begin
      take_jog_control(ch, first_byte, b, stamp);
    end
  endfunction

  // key events caused by one accepted item
  function automatic void decode_item(in_item_t it);
    logic [31:0] idle_ms;
    step_events.delete();
    if (it.operation == OP_POLL) begin
      idle_ms = it.time_ms - move_stamp;
      if (jog_dir != DIR_IDLE && idle_ms > {16'd0, dec_cfg.release_ms}) begin
        add_event(1'b0, (jog_dir == DIR_RIGHT) ? KEY_RIGHT : KEY_LEFT);
        jog_dir = DIR_IDLE;
      end
    end else begin
      take_midi_byte(it.data_byte, it.time_ms);
    end
    foreach (step_events[i]) begin
      step_events[i].last = (i == step_events.size() - 1);
      key_event_q.push_back(step_events[i]);
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_event(out_item_t got);
    out_item_t want;
    if (key_event_q.size() == 0) begin
      report_mismatch($sformatf("unexpected item pressed=%0d key=%0d last=%0d",
                                got.pressed, got.key_code, got.last));
      return;
    end
    want = key_event_q.pop_front();
    if (got.pressed !== want.pressed)
      report_mismatch($sformatf("pressed %0d, want %0d", got.pressed, want.pressed));
    if (got.key_code !== want.key_code)
      report_mismatch($sformatf("key_code %0d, want %0d", got.key_code, want.key_code));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
  endtask

  // result side: take each item, then stall a random number of cycles
  initial begin : result_checker
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        check_event(out_item);
        hold = pop_gaps ? $urandom_range(0, 18) : 0;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // one item: optional gap, then hold push until accepted
  task automatic send_item(logic op, logic [7:0] data, logic [31:0] stamp);
    int gap;
    in_item_t it;
    it.operation = op;
    it.data_byte = data;
    it.time_ms = stamp;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_item(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(OP_MIDI_BYTE, b, now_ms);
  endtask

  // system real-time and common bytes, never sysex start or end
  task automatic maybe_realtime();
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) begin
      b = 8'($urandom_range(8'hF1, 8'hFF));
      if (b == ST_SYSEX_END) b = 8'hF8;
      send_byte(b);
    end
  endtask

  // status byte, sometimes left out when running status already holds it
  task automatic send_status(logic [7:0] st);
    if (st != run_status || $urandom_range(0, 2) == 0) send_byte(st);
  endtask

  task automatic send_pair(logic [7:0] d1, logic [7:0] d2);
    send_byte(d1);
    maybe_realtime();
    send_byte(d2);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (key_event_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_BUTTON_CHANNEL: dec_cfg.button_channel = val[3:0];
      CFG_NAV_CHANNEL: dec_cfg.nav_channel = val[3:0];
      CFG_JOG_HIGH_CC: dec_cfg.jog_high_cc = val[6:0];
      CFG_JOG_LOW_CC: dec_cfg.jog_low_cc = val[6:0];
      CFG_RELEASE_MS: dec_cfg.release_ms = val[15:0];
      CFG_REVERSE_COUNT: dec_cfg.reverse_count = val[1:0];
      CFG_MIN_STEP: dec_cfg.min_step = val[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int button, int nav, int hi_cc, int lo_cc, int rel,
                                int rev, int min_delta);
    wait_idle();
    write_reg(CFG_BUTTON_CHANNEL, CFG_DATA_W'(button));
    write_reg(CFG_NAV_CHANNEL, CFG_DATA_W'(nav));
    write_reg(CFG_JOG_HIGH_CC, CFG_DATA_W'(hi_cc));
    write_reg(CFG_JOG_LOW_CC, CFG_DATA_W'(lo_cc));
    write_reg(CFG_RELEASE_MS, CFG_DATA_W'(rel));
    write_reg(CFG_REVERSE_COUNT, CFG_DATA_W'(rev));
    write_reg(CFG_MIN_STEP, CFG_DATA_W'(min_delta));
    cfg_wr_en <= 1'b0;
  endtask

  // one random message, mostly well formed, some noise
  task automatic send_random_message();
    int pick;
    int r;
    int n;
    int step;
    int span;
    logic [3:0] ch;
    logic [3:0] kind;
    logic [6:0] hi_ctl;
    logic [6:0] lo_ctl;
    logic [7:0] note;
    logic [7:0] vel;
    pick = $urandom_range(0, 99);
    now_ms += $urandom_range(0, 12);
    if (sysex_on && $urandom_range(0, 3) != 0) send_byte(ST_SYSEX_END);

    if (pick < 30) begin
      // note on or off, mostly on mapped channels and notes
      ch = $urandom_range(0, 1) ? dec_cfg.button_channel : dec_cfg.nav_channel;
      if ($urandom_range(0, 7) == 0) ch = 4'($urandom_range(0, 15));
      kind = ($urandom_range(0, 2) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
      case ($urandom_range(0, 13))
        0: note = 8'd10;
        1: note = 8'd9;
        2: note = 8'd8;
        3: note = 8'd15;
        4: note = 8'd16;
        5: note = 8'd17;
        6: note = 8'd18;
        7: note = 8'd4;
        8: note = 8'd3;
        9: note = 8'd7;
        10: note = 8'd6;
        default: note = 8'($urandom_range(0, 127));
      endcase
      r = $urandom_range(0, 3);
      vel = (r == 0) ? 8'd0 : (r == 1) ? 8'd127 : 8'($urandom_range(1, 126));
      send_status({kind, ch});
      send_pair(note, vel);
    end else if (pick < 62) begin
      // jog controller pair, walking with a drifting trend
      ch = dec_cfg.button_channel;
      if ($urandom_range(0, 9) == 0) ch = 4'($urandom_range(0, 15));
      send_status({KIND_CTRL, ch});
      r = $urandom_range(0, 19);
      if (r == 0) begin
        step = $urandom_range(0, 1) ? 8192 : -8192;
      end else if (r == 1) begin
        step = $urandom_range(0, 16383);
      end else begin
        span = int'(dec_cfg.min_step) + 3;
        step = $urandom_range(0, span);
        if ($urandom_range(0, 3) == 0) step = -step;
        step = step * jog_trend;
      end
      if ($urandom_range(0, 9) == 0) jog_trend = -jog_trend;
      jog_target = jog_target + step[13:0];
      hi_ctl = dec_cfg.jog_high_cc;
      lo_ctl = dec_cfg.jog_low_cc;
      if ($urandom_range(0, 11) == 0) hi_ctl = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 11) == 0) lo_ctl = 7'($urandom_range(0, 127));
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        send_pair({1'b0, hi_ctl}, {1'b0, jog_target[13:7]});
        send_pair({1'b0, lo_ctl}, {1'b0, jog_target[6:0]});
      end else if (r <= 7) begin
        send_pair({1'b0, lo_ctl}, {1'b0, jog_target[6:0]});
      end else if (r == 8) begin
        send_pair({1'b0, lo_ctl}, {1'b0, jog_target[6:0]});
        send_pair({1'b0, hi_ctl}, {1'b0, jog_target[13:7]});
      end else begin
        send_pair({1'b0, hi_ctl}, {1'b0, jog_target[13:7]});
      end
    end else if (pick < 74) begin
      // poll tick, around the release threshold or far away
      r = $urandom_range(0, 9);
      if (r < 6) now_ms += $urandom_range(0, int'(dec_cfg.release_ms) + 40);
      else if (r == 6) now_ms = move_stamp + {16'd0, dec_cfg.release_ms};
      else if (r == 7) now_ms = move_stamp + {16'd0, dec_cfg.release_ms} + 32'd1;
      else if (r == 8) now_ms += $urandom;
      send_item(OP_POLL, 8'($urandom_range(0, 255)), now_ms);
    end else if (pick < 80) begin
      // sysex block, sometimes with a channel status inside or left open
      send_byte(ST_SYSEX_START);
      n = $urandom_range(0, 6);
      repeat (n) begin
        r = $urandom_range(0, 7);
        if (r == 0) send_byte(8'h80 + 8'($urandom_range(0, 8'h6F)));
        else if (r == 1) maybe_realtime();
        else send_byte(8'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 4) != 0) send_byte(ST_SYSEX_END);
    end else if (pick < 87) begin
      // one-byte and unmapped channel messages, bare data
      ch = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: begin
          send_status({KIND_PROGRAM, ch});
          send_byte(8'($urandom_range(0, 127)));
        end
        1: begin
          send_status({KIND_PRESSURE, ch});
          send_byte(8'($urandom_range(0, 127)));
        end
        2: begin
          send_status({$urandom_range(0, 1) ? KIND_POLY_PRESSURE : KIND_PITCH_BEND, ch});
          send_pair(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
        end
        default: send_pair(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
      endcase
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_items(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 39) == 0) send_gaps = !send_gaps;
      if ($urandom_range(0, 39) == 0) pop_gaps = !pop_gaps;
      // now and then the sender holds off until all key events are out
      if ($urandom_range(0, 149) == 0) wait_idle();
      send_random_message();
    end
    send_gaps = 1'b1;
    pop_gaps = 1'b1;
  endtask

  // reset settings: parser corner cases, jog wrap and release over time wrap
  task automatic test_directed_messages();
    now_ms = 32'hFFFF_FFF0;
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(ST_SYSEX_START);
    send_byte({KIND_NOTE_ON, 4'd2});
    send_byte(8'd10);
    send_byte(ST_SYSEX_END);
    send_byte(8'd10);
    send_byte(8'hF8);
    send_byte(8'd127);
    send_pair(8'd9, 8'd0);
    send_byte({KIND_NOTE_OFF, 4'd15});
    send_pair(8'd4, 8'h40);
    send_byte({KIND_PROGRAM, 4'd2});
    send_byte(8'd5);
    send_byte({KIND_CTRL, 4'd2});
    send_pair(8'd55, 8'd64);
    send_pair(8'd77, 8'd0);
    send_pair(8'd77, 8'd2);
    send_item(OP_POLL, 8'hFF, 32'h0000_0040);
    send_item(OP_POLL, 8'h00, 32'h0000_0041);
    now_ms = 32'hFFFF_FFFF;
    send_pair(8'd55, 8'd0);
    send_pair(8'd77, 8'd2);
  endtask

  // all registers at their low ends, shared channel and controller
  task automatic test_low_extremes();
    apply_settings(0, 0, 0, 0, 0, 0, 0);
    now_ms = 32'hFFFF_F000;
    run_random_items(300);
  endtask

  // all registers at their high ends but the low jog controller, at 126
  task automatic test_high_extremes();
    apply_settings(15, 15, 127, 126, 65535, 3, 63);
    now_ms = $urandom;
    run_random_items(300);
  endtask

  // a few random settings in the typical range
  task automatic test_random_settings();
    repeat (3) begin
      apply_settings($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 127),
                     $urandom_range(0, 127), $urandom_range(0, 200), $urandom_range(0, 3),
                     $urandom_range(0, 8));
      now_ms = $urandom;
      run_random_items(350);
    end
  endtask

  initial begin
    reset_decoder();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_messages();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    wait_idle();
    if (key_event_q.size() != 0)
      report_mismatch($sformatf("%0d key events never came", key_event_q.size()));
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mtk_pkg.sv
hdl/mtk_fifo.sv
hdl/mtk_front.sv
hdl/mtk_back.sv
hdl/midi_to_key_event_decoder.sv
hdl/mtk_checker.sv
tb/sv/testbench.sv
